/* rtl/iwc_pkg.sv */
// shared types and constants of the irrigation watering controller
`default_nettype none

package iwc_pkg;

  // field widths
  localparam int unsigned OpW       = 2;
  localparam int unsigned SensorW   = 8;
  localparam int unsigned LimitW    = 7;
  localparam int unsigned MinutesW  = 4;
  localparam int unsigned SecondsW  = 11;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 7;

  // time base
  localparam logic [SecondsW-1:0] SEC_PER_MIN = SecondsW'(60);
  localparam logic [SecondsW-1:0] SEC_MAX     = {SecondsW{1'b1}};

  // register reset values
  localparam logic [LimitW-1:0]   TEMP_LIMIT_RST    = LimitW'(40);
  localparam logic [LimitW-1:0]   HUMIDITY_HIGH_RST = LimitW'(80);
  localparam logic [LimitW-1:0]   HUMIDITY_LOW_RST  = LimitW'(50);
  localparam logic [MinutesW-1:0] WATER_MIN_RST     = MinutesW'(1);
  localparam logic [MinutesW-1:0] REST_MIN_RST      = MinutesW'(1);
  localparam logic [MinutesW-1:0] ALARM_SEC_RST     = MinutesW'(1);

  typedef enum logic [OpW-1:0] {
    OP_TICK       = 2'd0,
    OP_READING    = 2'd1,
    OP_START_WATER = 2'd2,
    OP_START_REST = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WATER = 2'd1,
    MODE_REST  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_OPEN  = 2'd1,
    TURN_CLOSE = 2'd2
  } turn_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_TEMP_LIMIT    = 3'd0,
    CFG_HUMIDITY_HIGH = 3'd1,
    CFG_HUMIDITY_LOW  = 3'd2,
    CFG_WATER_MINUTES = 3'd3,
    CFG_REST_MINUTES  = 3'd4,
    CFG_ALARM_SECONDS = 3'd5
  } cfg_idx_e;

endpackage

`default_nettype wire

/* rtl/irrigation_watering_controller_core.sv */
// irrigation watering controller: mode state, timers, valve and beeper control
// One transaction per clock: an accepted item (tick, sensor reading or manual
// command) is folded into the controller state in the same cycle and its
// result appears on the output registers at the next edge. in_ready_o is high
// whenever the output register is empty or being drained, so the block
// sustains one item per cycle; the only limit is the single output register
// and the consumer's out_ready_i. Outputs show the state after the item:
// mode, valve position, beeper, the net valve turn of the step and the seconds
// counted in the running watering and rest cycle. Configuration registers are
// written with cfg_we_i and take effect for the next item; write them only
// while no transaction is in flight.
`default_nettype none

module irrigation_watering_controller_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [iwc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [iwc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input item
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [iwc_pkg::OpW-1:0]       op_i,
  input  wire logic [iwc_pkg::SensorW-1:0]   temperature_i,
  input  wire logic [iwc_pkg::SensorW-1:0]   humidity_i,
  // result item
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         mode_o,
  output logic                               valve_open_o,
  output logic                               beeper_on_o,
  output logic [1:0]                         turn_command_o,
  output logic [iwc_pkg::SecondsW-1:0]       elapsed_seconds_o
);
  import iwc_pkg::*;

  // configuration registers
  logic [LimitW-1:0]   temp_limit_q, humidity_high_q, humidity_low_q;
  logic [MinutesW-1:0] water_minutes_q, rest_minutes_q, alarm_seconds_q;

  // controller state
  mode_e               mode_q, mode_d;
  logic [SecondsW-1:0] sec_q, sec_d;
  logic                valve_q, valve_d;
  logic                beeper_q, beeper_d;
  logic [SensorW-1:0]  temp_q, temp_d;
  logic [SensorW-1:0]  hum_q, hum_d;
  logic                rd_valid_q, rd_valid_d;
  turn_e               turn_q, turn_d;
  logic                out_valid_q;

  logic                in_accept;
  logic [SecondsW-1:0] water_limit, rest_limit;
  op_e                 op;

  assign op        = op_e'(op_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept = in_valid_i && in_ready_o;

  // cycle lengths in seconds, fit in 11 bits for 4-bit minute fields
  assign water_limit = {{(SecondsW-MinutesW){1'b0}}, water_minutes_q} * SEC_PER_MIN;
  assign rest_limit  = ({{(SecondsW-MinutesW){1'b0}}, water_minutes_q} +
                        {{(SecondsW-MinutesW){1'b0}}, rest_minutes_q}) * SEC_PER_MIN;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_limit_q    <= TEMP_LIMIT_RST;
      humidity_high_q <= HUMIDITY_HIGH_RST;
      humidity_low_q  <= HUMIDITY_LOW_RST;
      water_minutes_q <= WATER_MIN_RST;
      rest_minutes_q  <= REST_MIN_RST;
      alarm_seconds_q <= ALARM_SEC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_TEMP_LIMIT:    temp_limit_q    <= cfg_wdata_i[LimitW-1:0];
        CFG_HUMIDITY_HIGH: humidity_high_q <= cfg_wdata_i[LimitW-1:0];
        CFG_HUMIDITY_LOW:  humidity_low_q  <= cfg_wdata_i[LimitW-1:0];
        CFG_WATER_MINUTES: water_minutes_q <= cfg_wdata_i[MinutesW-1:0];
        CFG_REST_MINUTES:  rest_minutes_q  <= cfg_wdata_i[MinutesW-1:0];
        CFG_ALARM_SECONDS: alarm_seconds_q <= cfg_wdata_i[MinutesW-1:0];
        default: ;
      endcase
    end
  end

  // next state for one item: count, timed checks, item, automatic checks
  always_comb begin
    logic auto_en;
    auto_en    = 1'b0;
    mode_d     = mode_q;
    sec_d      = sec_q;
    valve_d    = valve_q;
    beeper_d   = beeper_q;
    temp_d     = temp_q;
    hum_d      = hum_q;
    rd_valid_d = rd_valid_q;

    // second count while a cycle runs, saturating
    if (op == OP_TICK && mode_q != MODE_IDLE && sec_q != SEC_MAX) begin
      sec_d = sec_q + SecondsW'(1);
    end

    // alarm end and watering end
    if (mode_d == MODE_WATER) begin
      if (sec_d >= {{(SecondsW-MinutesW){1'b0}}, alarm_seconds_q}) begin
        beeper_d = 1'b0;
      end
      if (sec_d >= water_limit) begin
        mode_d   = MODE_REST;
        beeper_d = 1'b0;
        valve_d  = 1'b0;
      end
    end
    // rest end
    if (mode_d == MODE_REST && sec_d >= rest_limit) begin
      mode_d = MODE_IDLE;
    end
    if (mode_d == MODE_IDLE) begin
      sec_d = '0;
    end

    // apply the item
    case (op)
      OP_READING: begin
        temp_d     = temperature_i;
        hum_d      = humidity_i;
        rd_valid_d = 1'b1;
        auto_en    = 1'b1;
      end
      OP_START_WATER: begin
        mode_d   = MODE_WATER;
        beeper_d = 1'b1;
        valve_d  = 1'b1;
      end
      OP_START_REST: begin
        mode_d   = MODE_REST;
        beeper_d = 1'b0;
        valve_d  = 1'b0;
      end
      default: begin
        auto_en = 1'b1;
      end
    endcase

    // automatic humidity and temperature checks
    if (auto_en && rd_valid_d) begin
      if (mode_d == MODE_IDLE) begin
        if (hum_d <= {1'b0, humidity_low_q} ||
            (hum_d < {1'b0, humidity_high_q} && temp_d >= {1'b0, temp_limit_q})) begin
          mode_d   = MODE_WATER;
          beeper_d = 1'b1;
          valve_d  = 1'b1;
        end
      end
      if (hum_d >= {1'b0, humidity_high_q} && mode_d != MODE_REST) begin
        mode_d   = MODE_REST;
        beeper_d = 1'b0;
        valve_d  = 1'b0;
      end
    end

    // net valve movement of the step
    if (!valve_q && valve_d) begin
      turn_d = TURN_OPEN;
    end else if (valve_q && !valve_d) begin
      turn_d = TURN_CLOSE;
    end else begin
      turn_d = TURN_NONE;
    end
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      sec_q       <= '0;
      valve_q     <= 1'b0;
      beeper_q    <= 1'b0;
      temp_q      <= '0;
      hum_q       <= '0;
      rd_valid_q  <= 1'b0;
      turn_q      <= TURN_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        mode_q     <= mode_d;
        sec_q      <= sec_d;
        valve_q    <= valve_d;
        beeper_q   <= beeper_d;
        temp_q     <= temp_d;
        hum_q      <= hum_d;
        rd_valid_q <= rd_valid_d;
        turn_q     <= turn_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign mode_o            = mode_q;
  assign valve_open_o      = valve_q;
  assign beeper_on_o       = beeper_q;
  assign turn_command_o    = turn_q;
  assign elapsed_seconds_o = sec_q;

  // valve is open exactly while watering
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (valve_open_o == (mode_o == MODE_WATER)))
    else $error("valve position disagrees with mode");

  // beeper only sounds during watering
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && beeper_on_o) |-> (mode_o == MODE_WATER))
    else $error("beeper on outside watering");

  // idle keeps the cycle count cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_o == MODE_IDLE) |-> (elapsed_seconds_o == '0))
    else $error("seconds counted while idle");

  // an open turn command matches the valve opening from closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && turn_d == TURN_OPEN) |=> valve_open_o && !$past(valve_q))
    else $error("open command without valve opening");

endmodule

`default_nettype wire
